// ----- rtl/ccc_pkg.sv -----
// Shared types, codes and calendar helpers for the calendar clock counter.
package ccc_pkg;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_ADJUST = 1'b1
  } ccc_op_t;

  typedef enum logic [2:0] {
    SEL_YEAR   = 3'd0,
    SEL_MONTH  = 3'd1,
    SEL_DAY    = 3'd2,
    SEL_HOUR   = 3'd3,
    SEL_MINUTE = 3'd4,
    SEL_SECOND = 3'd5
  } ccc_sel_t;

  typedef struct packed {
    ccc_op_t           op;
    logic [2:0]        sel;
    logic signed [7:0] delta;
  } ccc_item_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } ccc_time_t;

  localparam logic [13:0] YEAR_RESET  = 14'd1970;
  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;
  localparam logic [4:0]  DAY_FIRST   = 5'd1;
  localparam logic [4:0]  HOURS       = 5'd24;
  localparam logic [5:0]  SIXTY       = 6'd60;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  localparam ccc_time_t TIME_RESET = '{
    year:   YEAR_RESET,
    month:  MONTH_FIRST,
    day:    DAY_FIRST,
    hour:   5'd0,
    minute: 6'd0,
    second: 6'd0
  };

  function automatic logic [4:0] month_length(input logic [3:0] month,
                                              input logic [13:0] year);
    logic [4:0] len;
    case (month)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_FEB: len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Adds a signed step to an unsigned value and clamps the sum to [lo, hi].
  function automatic logic [13:0] clamp_add(input logic [13:0] value,
                                            input logic signed [7:0] delta,
                                            input logic [13:0] lo,
                                            input logic [13:0] hi);
    logic signed [15:0] sum;
    logic [13:0]        res;
    sum = $signed({2'b00, value}) + 16'(delta);
    if (sum < $signed({2'b00, lo})) begin
      res = lo;
    end else if (sum > $signed({2'b00, hi})) begin
      res = hi;
    end else begin
      res = sum[13:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/ccc_if.sv -----
// Valid/ready channel interfaces for the request and result beats.
interface ccc_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [2:0]        field_select;
  logic signed [7:0] delta;

  modport source (output valid, output operation, output field_select, output delta,
                  input ready);
  modport sink (input valid, input operation, input field_select, input delta,
                output ready);
endinterface

interface ccc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  out_seconds;
  logic [5:0]  out_minutes;
  logic [4:0]  out_hours;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [13:0] out_year;

  modport source (output valid, output out_seconds, output out_minutes, output out_hours,
                  output out_day, output out_month, output out_year, input ready);
  modport sink (input valid, input out_seconds, input out_minutes, input out_hours,
                input out_day, input out_month, input out_year, output ready);
endinterface

// ----- rtl/ccc_in_stage.sv -----
// Input register stage: captures one request beat and holds it until it is consumed.
module ccc_in_stage (
  input  logic              clk,
  input  logic              rst,
  ccc_in_if.sink            request,
  input  logic              advance,
  output logic              item_valid,
  output ccc_pkg::ccc_item_t item
);
  import ccc_pkg::*;

  assign request.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (request.ready) begin
      item_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      item.op    <= ccc_op_t'(request.operation);
      item.sel   <= request.field_select;
      item.delta <= request.delta;
    end
  end

endmodule

// ----- rtl/ccc_time_core.sv -----
// Time and date registers with the one-second carry chain and the clamped field adjust.
module ccc_time_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  ccc_pkg::ccc_item_t item,
  output ccc_pkg::ccc_time_t time_next
);
  import ccc_pkg::*;

  ccc_time_t now;
  ccc_time_t tick_time;
  ccc_time_t adj_time;

  logic [5:0] sec_inc;
  logic [5:0] min_inc;
  logic [4:0] hour_inc;
  logic [5:0] day_inc;
  logic [3:0] month_inc;
  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic       day_wrap;
  logic       month_wrap;
  logic [4:0] cur_len;

  assign cur_len = month_length(now.month, now.year);

  // The day check runs on every tick, so a day left past the month end by an
  // adjust rolls over to the next month on the very next tick.
  always_comb begin
    sec_inc    = now.second + 6'd1;
    sec_wrap   = (sec_inc >= SIXTY);
    min_inc    = now.minute + {5'd0, sec_wrap};
    min_wrap   = (min_inc >= SIXTY);
    hour_inc   = now.hour + {4'd0, min_wrap};
    hour_wrap  = (hour_inc >= HOURS);
    day_inc    = {1'b0, now.day} + {5'd0, hour_wrap};
    day_wrap   = (day_inc > {1'b0, cur_len});
    month_inc  = now.month + {3'd0, day_wrap};
    month_wrap = (month_inc > MONTH_LAST);

    tick_time.second = sec_wrap  ? 6'd0 : sec_inc;
    tick_time.minute = min_wrap  ? 6'd0 : min_inc;
    tick_time.hour   = hour_wrap ? 5'd0 : hour_inc;
    tick_time.day    = day_wrap  ? DAY_FIRST : day_inc[4:0];
    tick_time.month  = month_wrap ? MONTH_FIRST : month_inc;
    tick_time.year   = (month_wrap && (now.year < YEAR_MAX)) ? now.year + 14'd1 : now.year;
  end

  always_comb begin
    adj_time = now;
    unique case (item.sel)
      SEL_YEAR:   adj_time.year = clamp_add(now.year, item.delta, 14'd0, YEAR_MAX);
      SEL_MONTH:  adj_time.month = 4'(clamp_add({10'd0, now.month}, item.delta,
                                                {10'd0, MONTH_FIRST},
                                                {10'd0, MONTH_LAST}));
      SEL_DAY:    adj_time.day = 5'(clamp_add({9'd0, now.day}, item.delta,
                                              {9'd0, DAY_FIRST}, {9'd0, cur_len}));
      SEL_HOUR:   adj_time.hour = 5'(clamp_add({9'd0, now.hour}, item.delta,
                                               14'd0, {9'd0, HOURS - 5'd1}));
      SEL_MINUTE: adj_time.minute = 6'(clamp_add({8'd0, now.minute}, item.delta,
                                                 14'd0, {8'd0, SIXTY - 6'd1}));
      SEL_SECOND: adj_time.second = 6'(clamp_add({8'd0, now.second}, item.delta,
                                                 14'd0, {8'd0, SIXTY - 6'd1}));
      default:    adj_time = now;
    endcase
  end

  assign time_next = (item.op == OP_TICK) ? tick_time : adj_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      now <= TIME_RESET;
    end else if (fire) begin
      now <= time_next;
    end
  end

endmodule

// ----- rtl/calendar_clock_counter.sv -----
// Calendar clock counter top level: input stage, time core and result register.
// Usage:
// The request channel carries one beat per item: operation selects a
// one-second tick or an adjust, and for an adjust field_select names the
// field (year, month, day, hour, minute, second) and delta is the signed
// step, clamped to that field's legal range. Every request beat produces
// exactly one result beat on the result channel with the full time and
// date after the item.
// A request beat is captured in the input register, and when the item
// advances the carry and clamp result is written into the result register.
// Throughput is one item per cycle while result ready stays high;
// the carry chain from seconds to year is a single pass of narrow adders
// and compares.
// Reset (synchronous, active high) sets the time to 1970-01-01 00:00:00
// and empties both stages. When the receiver holds result ready low, the
// result register holds its beat, the input register keeps one more item,
// and request ready then drops until the result is taken.
module calendar_clock_counter (
  input  logic clk,
  input  logic rst,
  ccc_in_if.sink    request,
  ccc_out_if.source result
);
  import ccc_pkg::*;

  logic      item_valid;
  ccc_item_t item;
  logic      advance;
  ccc_time_t time_next;
  logic      out_valid;
  ccc_time_t out_time;

  assign advance = item_valid && (!out_valid || result.ready);

  ccc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ccc_time_core u_time_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .item      (item),
    .time_next (time_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_time <= time_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.out_seconds = out_time.second;
  assign result.out_minutes = out_time.minute;
  assign result.out_hours   = out_time.hour;
  assign result.out_day     = out_time.day;
  assign result.out_month   = out_time.month;
  assign result.out_year    = out_time.year;

`ifndef SYNTHESIS
  // Every field of a result beat always lies within its own legal range.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_time.second < SIXTY) && (out_time.minute < SIXTY) &&
                  (out_time.hour < HOURS) && (out_time.day >= DAY_FIRST) &&
                  (out_time.month >= MONTH_FIRST) && (out_time.month <= MONTH_LAST) &&
                  (out_time.year <= YEAR_MAX))
    else $error("result beat out of range");

  // An item that leaves the input stage always lands in the result register.
  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item did not reach the result register");

  // A held item is never dropped from the input stage.
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !advance) |=> (item_valid && $stable(item)))
    else $error("stalled item lost in input stage");
`endif

endmodule

// ----- dv/tb_calendar_clock_counter.sv -----
// Self-checking testbench for the calendar clock counter with its scoreboard class.
`timescale 1ns / 1ps

module tb_calendar_clock_counter;
  import ccc_pkg::*;

  // Tracks the calendar time that the block should hold and the results still owed.
  class calendar_scoreboard;
    int year;
    int month;
    int day;
    int hour;
    int minute;
    int second;
    ccc_time_t expected_times[$];
    int errors;

    function new();
      year   = 1970;
      month  = 1;
      day    = 1;
      hour   = 0;
      minute = 0;
      second = 0;
      errors = 0;
    endfunction

    function int days_in_month(int m, int y);
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      if (m == 2) return (y % 4 == 0) ? 29 : 28;
      return 31;
    endfunction

    function int saturate(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void advance_one_second();
      second++;
      if (second >= 60) begin
        second = 0;
        minute++;
      end
      if (minute >= 60) begin
        minute = 0;
        hour++;
      end
      if (hour >= 24) begin
        hour = 0;
        day++;
      end
      // A day left beyond the month end by an earlier adjust also lands here.
      if (day > days_in_month(month, year)) begin
        day = 1;
        month++;
      end
      if (month > 12) begin
        month = 1;
        if (year < 9999) year++;
      end
    endfunction

    function void note_request(ccc_op_t op, logic [2:0] sel, logic signed [7:0] delta);
      int d;
      ccc_time_t t;
      d = delta;
      if (op == OP_TICK) begin
        advance_one_second();
      end else begin
        case (sel)
          SEL_YEAR:   year   = saturate(year + d, 0, 9999);
          SEL_MONTH:  month  = saturate(month + d, 1, 12);
          SEL_DAY:    day    = saturate(day + d, 1, days_in_month(month, year));
          SEL_HOUR:   hour   = saturate(hour + d, 0, 23);
          SEL_MINUTE: minute = saturate(minute + d, 0, 59);
          SEL_SECOND: second = saturate(second + d, 0, 59);
          default: ;
        endcase
      end
      t.year   = 14'(year);
      t.month  = 4'(month);
      t.day    = 5'(day);
      t.hour   = 5'(hour);
      t.minute = 6'(minute);
      t.second = 6'(second);
      expected_times.push_back(t);
    endfunction

    function void compare_field(string name, int exp, logic [13:0] act);
      if (act !== 14'(exp)) begin
        $error("%s: expected %0d, actual %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(ccc_time_t got);
      ccc_time_t exp;
      if (expected_times.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      exp = expected_times.pop_front();
      compare_field("out_seconds", exp.second, got.second);
      compare_field("out_minutes", exp.minute, got.minute);
      compare_field("out_hours", exp.hour, got.hour);
      compare_field("out_day", exp.day, got.day);
      compare_field("out_month", exp.month, got.month);
      compare_field("out_year", exp.year, got.year);
    endfunction

    function int pending();
      return expected_times.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  ccc_in_if  req_if ();
  ccc_out_if res_if ();

  calendar_clock_counter i_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  calendar_scoreboard sb = new();

  int burst_left;
  int items_sent;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(ccc_op_t op, logic [2:0] sel, logic signed [7:0] delta);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    req_if.valid        <= 1'b1;
    req_if.operation    <= op;
    req_if.field_select <= sel;
    req_if.delta        <= delta;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(op, sel, delta);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  // Moves the clock to 23:59:59, then backs the seconds off by slack.
  task automatic near_midnight(int slack);
    send_item(OP_ADJUST, SEL_HOUR, 127);
    send_item(OP_ADJUST, SEL_MINUTE, 127);
    send_item(OP_ADJUST, SEL_SECOND, 127);
    if (slack != 0) send_item(OP_ADJUST, SEL_SECOND, 8'(-slack));
  endtask

  // Receiver: switches between always ready, scattered stalls and long stalls.
  initial begin
    int mode;
    int mode_left;
    int stall;
    res_if.ready = 1'b0;
    mode_left = 0;
    mode = 0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= ($urandom_range(0, 2) != 0);
        default: begin
          if (stall > 0) begin
            stall--;
            res_if.ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall = $urandom_range(3, 20);
            res_if.ready <= 1'b0;
          end else begin
            res_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    ccc_time_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got.second = res_if.out_seconds;
      got.minute = res_if.out_minutes;
      got.hour   = res_if.out_hours;
      got.day    = res_if.out_day;
      got.month  = res_if.out_month;
      got.year   = res_if.out_year;
      sb.check_result(got);
    end
  end

  initial begin
    #5_000_000;
    $display("tb_calendar_clock_counter NOT OK");
    $finish;
  end

  initial begin
    int scenario;
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.operation = 1'b0;
    req_if.field_select = 3'd0;
    req_if.delta = 8'sd0;
    burst_left = 0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset value, field extremes, unused selectors and a zero step.
    send_item(OP_TICK, SEL_YEAR, 0);
    send_item(OP_ADJUST, SEL_YEAR, 127);
    send_item(OP_ADJUST, SEL_YEAR, -128);
    send_item(OP_ADJUST, SEL_YEAR, 0);
    send_item(OP_ADJUST, 3'd6, 5);
    send_item(OP_ADJUST, 3'd7, -1);
    // Leap February: 1972-02-29 23:59:59 rolls into March.
    send_item(OP_ADJUST, SEL_YEAR, 3);
    send_item(OP_ADJUST, SEL_MONTH, 1);
    send_item(OP_ADJUST, SEL_DAY, 127);
    near_midnight(0);
    send_item(OP_TICK, SEL_YEAR, 0);
    // Day 31 carried into April by a month adjust, then a day carry.
    send_item(OP_ADJUST, SEL_DAY, 127);
    send_item(OP_ADJUST, SEL_MONTH, 1);
    near_midnight(0);
    send_item(OP_TICK, SEL_YEAR, 0);
    send_item(OP_ADJUST, SEL_SECOND, -128);
    send_item(OP_ADJUST, SEL_MINUTE, -128);
    send_item(OP_ADJUST, SEL_HOUR, -1);
    send_item(OP_ADJUST, SEL_MONTH, -128);

    while (items_sent < 1750) begin
      scenario = $urandom_range(0, 9);
      case (scenario)
        4, 5: begin
          near_midnight($urandom_range(0, 3));
          if ($urandom_range(0, 1) == 0) send_item(OP_ADJUST, SEL_DAY, 127);
          if ($urandom_range(0, 3) == 0) send_item(OP_ADJUST, SEL_MONTH, 127);
          repeat ($urandom_range(1, 6)) send_item(OP_TICK, 3'($urandom), 8'($urandom));
        end
        6: begin
          // Drive the year to one end of its range, then cross a year boundary.
          if ($urandom_range(0, 1) == 0) begin
            while (sb.year < 9999) send_item(OP_ADJUST, SEL_YEAR, 127);
          end else begin
            while (sb.year > 0) send_item(OP_ADJUST, SEL_YEAR, -128);
          end
          send_item(OP_ADJUST, SEL_MONTH, 127);
          send_item(OP_ADJUST, SEL_DAY, 127);
          near_midnight(0);
          repeat ($urandom_range(1, 3)) send_item(OP_TICK, SEL_YEAR, 0);
        end
        7: begin
          send_item(OP_ADJUST, SEL_YEAR, 8'($urandom_range(0, 6) - 3));
          send_item(OP_ADJUST, SEL_MONTH, -128);
          send_item(OP_ADJUST, SEL_MONTH, 1);
          send_item(OP_ADJUST, SEL_DAY, 127);
          near_midnight($urandom_range(0, 2));
          repeat ($urandom_range(1, 4)) send_item(OP_TICK, SEL_YEAR, 0);
        end
        8: begin
          // A long day left in a shorter month must still carry correctly.
          send_item(OP_ADJUST, SEL_MONTH, -128);
          send_item(OP_ADJUST, SEL_DAY, 127);
          send_item(OP_ADJUST, SEL_MONTH, 8'($urandom_range(1, 11)));
          if ($urandom_range(0, 2) == 0) send_item(OP_ADJUST, SEL_DAY, 0);
          near_midnight(0);
          repeat ($urandom_range(1, 3)) send_item(OP_TICK, SEL_YEAR, 0);
        end
        9: begin
          repeat ($urandom_range(5, 20))
            send_item(ccc_op_t'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)));
        end
        default: begin
          repeat ($urandom_range(10, 40)) begin
            if ($urandom_range(0, 3) != 0)
              send_item(OP_TICK, 3'($urandom), 8'($urandom));
            else if ($urandom_range(0, 1) == 0)
              send_item(OP_ADJUST, 3'($urandom_range(0, 5)),
                        8'($urandom_range(0, 16) - 8));
            else
              send_item(OP_ADJUST, 3'($urandom_range(0, 5)), 8'($urandom_range(0, 255)));
          end
        end
      endcase
    end

    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_calendar_clock_counter OK");
    end else begin
      $display("tb_calendar_clock_counter NOT OK");
    end
    $finish;
  end

endmodule
